### sv/jdd_pkg.sv
// jdd_pkg: shared constants and types for the joystick datagram deframer
// no dependencies; imported by joystick_datagram_deframer_top

package jdd_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int SKIP_BYTES  = 3;
   localparam int POS_W       = $clog2(FRAME_BYTES + 2);
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int RX_W        = 8;
   localparam int AXIS_W      = 32;
   localparam int BTN_W       = 16;
   localparam int CNT_W       = 16;
   localparam int RSP_DATA_W  = 3 * AXIS_W + BTN_W + CNT_W;

   localparam logic [RX_W-1:0] SYNC_RESET = 8'h2A;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_CONFIRM = 2'd1,
      PH_SKIP    = 2'd2,
      PH_COLLECT = 2'd3
   } phase_type;

   typedef logic [RX_W-1:0]       rx_byte_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

endpackage

### sv/joystick_datagram_deframer_top.sv
// joystick_datagram_deframer_top: byte stream in, decoded joystick frames out
// depends on jdd_pkg
//
// channel  dir  signals                          per word
// req      in   req_tvalid/tready/tdata[7:0]     one received byte
// rsp      out  rsp_tvalid/tready/tdata/tuser    one decoded frame or frame error
// csr      in   csr_we/csr_wdata[7:0]            sync character write
//
// one byte per cycle while req_tready is high; a byte is decoded in the cycle it
// is accepted and any result appears in the output register on the next cycle
// a frame result follows the last byte of each collected frame
// reset clears phase, position, error count and output valid; sync char = '*'
// req_tready drops only while the output register is full and not taken

module joystick_datagram_deframer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  jdd_pkg::rx_byte_type        req_tdata,   // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output jdd_pkg::rsp_data_type       rsp_tdata,   // axis_x_bits, axis_y_bits,
                                                    // axis_z_bits, button_bits,
                                                    // bad_frame_total
   output logic                        rsp_tuser,   // [0] frame_bad
   input  logic                        csr_we,
   input  jdd_pkg::rx_byte_type        csr_wdata    // [7:0] sync_char
);
   import jdd_pkg::*;

   phase_type    phase_ff, phase_in;
   pos_type      pos_ff, pos_in, pos_inc;
   cnt_type      bad_ff, bad_in;
   rx_byte_type  sync_ff;
   rx_byte_type  store_ff [FRAME_BYTES];
   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         rsp_bad_ff, rsp_bad_in;
   logic         emit;
   logic         accept;
   logic         store_we;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;
   assign pos_inc    = pos_ff + 1'b1;
   assign store_we   = accept && (phase_ff == PH_COLLECT);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         bad_ff   <= '0;
         sync_ff  <= SYNC_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            bad_ff   <= bad_in;
         end
         if (csr_we) begin
            sync_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[pos_ff[IDX_W-1:0]] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      bad_in      = bad_ff;
      emit        = 1'b0;
      rsp_data_in = '0;
      rsp_bad_in  = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (req_tdata == sync_ff) begin
               phase_in = PH_CONFIRM;
               pos_in   = '0;
            end
         end
         PH_CONFIRM: begin
            if (pos_ff <= POS_W'(FRAME_BYTES)) begin
               pos_in = pos_inc;
            end
            if (pos_in == POS_W'(FRAME_BYTES) && req_tdata == sync_ff) begin
               phase_in = PH_SKIP;
               pos_in   = '0;
            end else if (pos_in > POS_W'(FRAME_BYTES)) begin
               phase_in = PH_HUNT;
            end
         end
         PH_SKIP: begin
            pos_in = pos_inc;
            if (pos_inc >= POS_W'(SKIP_BYTES)) begin
               phase_in = PH_COLLECT;
               pos_in   = '0;
            end
         end
         PH_COLLECT: begin
            pos_in = pos_inc;
            if (pos_inc == POS_W'(FRAME_BYTES)) begin
               emit   = 1'b1;
               pos_in = '0;
               if (store_ff[FRAME_BYTES-4] == sync_ff) begin
                  rsp_data_in = {bad_ff,
                                 store_ff[FRAME_BYTES-2], req_tdata,
                                 store_ff[11], store_ff[10], store_ff[9], store_ff[8],
                                 store_ff[7], store_ff[6], store_ff[5], store_ff[4],
                                 store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
               end else begin
                  if (bad_ff != '1) begin
                     bad_in = bad_ff + 1'b1;
                  end
                  phase_in    = PH_HUNT;
                  rsp_bad_in  = 1'b1;
                  rsp_data_in = {bad_in, {(RSP_DATA_W-CNT_W){1'b0}}};
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_bad_clears_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[RSP_DATA_W-CNT_W-1:0] == '0)
      else $error("bad frame result carries payload");

   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> bad_ff >= $past(bad_ff))
      else $error("bad frame count went down");

   a_collect_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COLLECT |-> pos_ff < POS_W'(FRAME_BYTES))
      else $error("collect position out of range");

   a_skip_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> pos_ff < POS_W'(SKIP_BYTES))
      else $error("skip position out of range");

   a_result_from_collect: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff) == PH_COLLECT)
      else $error("result raised outside collect");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for joystick_datagram_deframer_top, byte stream in, frames out
// depends on jdd_pkg and the deframer rtl; holds its own frame decoder and result scoreboard

import jdd_pkg::*;

typedef struct packed {
   logic [AXIS_W-1:0] axis_x;
   logic [AXIS_W-1:0] axis_y;
   logic [AXIS_W-1:0] axis_z;
   logic [BTN_W-1:0]  buttons;
   logic              frame_bad;
   cnt_type           bad_total;
} frame_result_type;

class frame_scoreboard;
   rx_byte_type      sync_char;
   phase_type        phase;
   int               pos;
   rx_byte_type      store [FRAME_BYTES];
   cnt_type          bad_count;
   frame_result_type frames_due [$];
   int               frames_checked;
   int               bad_frames_seen;

   function new();
      sync_char       = SYNC_RESET;
      phase           = PH_HUNT;
      pos             = 0;
      bad_count       = '0;
      frames_checked  = 0;
      bad_frames_seen = 0;
   endfunction

   // advance the decoder by one accepted byte, queue a frame result when one is due
   function void decode_byte(rx_byte_type b);
      frame_result_type r;
      r = '0;
      case (phase)
         PH_HUNT: begin
            if (b == sync_char) begin
               phase = PH_CONFIRM;
               pos   = 0;
            end
         end
         PH_CONFIRM: begin
            if (pos <= FRAME_BYTES) pos++;
            if (pos == FRAME_BYTES && b == sync_char) begin
               phase = PH_SKIP;
               pos   = 0;
            end else if (pos > FRAME_BYTES) begin
               phase = PH_HUNT;
            end
         end
         PH_SKIP: begin
            pos++;
            if (pos >= SKIP_BYTES) begin
               phase = PH_COLLECT;
               pos   = 0;
            end
         end
         PH_COLLECT: begin
            store[pos] = b;
            pos++;
            if (pos >= FRAME_BYTES) begin
               if (store[FRAME_BYTES-4] == sync_char) begin
                  r.axis_x  = {store[3], store[2], store[1], store[0]};
                  r.axis_y  = {store[7], store[6], store[5], store[4]};
                  r.axis_z  = {store[11], store[10], store[9], store[8]};
                  r.buttons = {store[FRAME_BYTES-2], store[FRAME_BYTES-1]};
               end else begin
                  if (bad_count != '1) bad_count++;
                  r.frame_bad = 1'b1;
                  phase       = PH_HUNT;
                  bad_frames_seen++;
               end
               r.bad_total = bad_count;
               pos         = 0;
               frames_due.push_back(r);
            end
         end
      endcase
   endfunction

   function int check_frame(rsp_data_type d, logic bad, output string why);
      frame_result_type e;
      why = "";
      if (frames_due.size() == 0) begin
         why = $sformatf("frame result %h/%b with nothing expected", d, bad);
         return 1;
      end
      e = frames_due.pop_front();
      frames_checked++;
      if (d[0 +: AXIS_W] !== e.axis_x)
         why = {why, $sformatf(" axis_x %h want %h", d[0 +: AXIS_W], e.axis_x)};
      if (d[AXIS_W +: AXIS_W] !== e.axis_y)
         why = {why, $sformatf(" axis_y %h want %h", d[AXIS_W +: AXIS_W], e.axis_y)};
      if (d[2*AXIS_W +: AXIS_W] !== e.axis_z)
         why = {why, $sformatf(" axis_z %h want %h", d[2*AXIS_W +: AXIS_W], e.axis_z)};
      if (d[3*AXIS_W +: BTN_W] !== e.buttons)
         why = {why, $sformatf(" buttons %h want %h", d[3*AXIS_W +: BTN_W], e.buttons)};
      if (d[3*AXIS_W+BTN_W +: CNT_W] !== e.bad_total)
         why = {why, $sformatf(" bad_total %0d want %0d",
                               d[3*AXIS_W+BTN_W +: CNT_W], e.bad_total)};
      if (bad !== e.frame_bad)
         why = {why, $sformatf(" frame_bad %b want %b", bad, e.frame_bad)};
      return (why != "");
   endfunction

   function int pending();
      return frames_due.size();
   endfunction
endclass

module tb;

   localparam int ITEMS       = 1100;
   localparam int PHASE_BYTES = 140;
   localparam int QUIET_LIMIT = 2000;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   rx_byte_type  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   rsp_data_type rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we;
   rx_byte_type  csr_wdata;

   frame_scoreboard board = new();
   int           errors        = 0;
   int           sent          = 0;
   int           quiet         = 0;
   int           req_idle_pct  = 0;
   int           rsp_stall_pct = 0;
   int           phases_run    = 0;

   joystick_datagram_deframer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report(input string why);
      errors++;
      $display("mismatch at %0t:%s", $time, why);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor: note accepted bytes, check accepted results, watch for a hang
   always @(posedge clock) begin
      string why;
      if (!reset) begin
         if (req_tvalid && req_tready) board.decode_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (board.check_frame(rsp_tdata, rsp_tuser, why) != 0) report(why);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_byte(input rx_byte_type b);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= rx_byte_type'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   // fill < 0 gives random content; the sync slot holds the sync char only when good
   task automatic send_frame(input int fill, input bit good, input int len);
      rx_byte_type b;
      for (int i = 0; i < len; i++) begin
         b = (fill < 0) ? rx_byte_type'($urandom) : rx_byte_type'(fill);
         if (i == FRAME_BYTES - 4)
            b = good ? board.sync_char : board.sync_char ^ rx_byte_type'($urandom_range(1, 255));
         send_byte(b);
      end
   endtask

   task automatic send_burst();
      int count;
      int kind;
      if ($urandom_range(9) == 0) begin
         count = $urandom_range(5, 30);
         repeat (count) send_byte(rx_byte_type'($urandom));
      end else begin
         count = $urandom_range(0, 3);
         repeat (count) send_byte(rx_byte_type'($urandom));
         count = $urandom_range(3, 9);
         repeat (count) begin
            kind = $urandom_range(99);
            if (kind < 78) send_frame(-1, 1'b1, FRAME_BYTES);
            else if (kind < 88) send_frame(-1, 1'b0, FRAME_BYTES);
            else if (kind < 94) send_frame(-1, 1'b1, FRAME_BYTES - 1);
            else send_frame(-1, 1'b1, FRAME_BYTES + 1);
         end
      end
   endtask

   // called with req_tvalid already low
   task automatic set_sync(input rx_byte_type v);
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we          <= 1'b0;
      board.sync_char = v;
   endtask

   initial begin
      int p;
      int phase_end;
      rx_byte_type v;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // hunt drops the extremes, then lock, all-zero and all-ones frames, a bad frame
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h00, 1'b1, FRAME_BYTES);
      send_frame(8'h00, 1'b1, FRAME_BYTES);
      send_frame(8'h00, 1'b1, FRAME_BYTES);
      send_frame(8'hFF, 1'b1, FRAME_BYTES);
      send_frame(-1, 1'b0, FRAME_BYTES);
      // confirm miss: sync, a frame length without sync, then a sync that is swallowed
      send_byte(board.sync_char);
      repeat (FRAME_BYTES) send_byte(board.sync_char ^ rx_byte_type'($urandom_range(1, 255)));
      send_byte(board.sync_char);

      for (p = 0; sent < ITEMS; p++) begin
         case (p % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 56; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin req_idle_pct = 29; rsp_stall_pct = 29; end
         endcase
         if (p > 0) begin
            case (p)
               1: v = 8'h00;
               2: v = 8'hFF;
               4: v = SYNC_RESET;
               default: v = rx_byte_type'($urandom);
            endcase
            set_sync(v);
         end
         phase_end = sent + PHASE_BYTES;
         while (sent < phase_end) send_burst();
         req_tvalid <= 1'b0;
         phases_run++;
      end

      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      $display("ran %0d bytes over %0d phases of sync char and idling, sync 00 and ff included",
               sent, phases_run);
      $display("checked %0d frame results, %0d of them bad frames", board.frames_checked,
               board.bad_frames_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
